>>> rtl/grl_pkg.sv
`timescale 1ns / 1ps
// grl_pkg: shared types, codes and sizes for the glyph run layout block
// no dependencies; used by every file under rtl

package grl_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int MAX_INSTANCES = 128;
    localparam int CNT_W         = $clog2(MAX_INSTANCES + 1);
    localparam int SLOT_W        = 7;
    localparam int ID_W          = 11;
    localparam int ID_SCALE      = 6;
    localparam int RGB_W         = 24;

    localparam logic [8:0]  TABLE_DEPTH_W = 9'(TABLE_DEPTH);
    localparam logic [15:0] MAX_INST_W    = 16'(MAX_INSTANCES);

    localparam logic [7:0]       RST_FIRST_CODE  = 8'd32;
    localparam logic [8:0]       RST_GLYPH_COUNT = 9'd0;
    localparam logic [7:0]       RST_INST_LIMIT  = 8'd128;
    localparam logic [RGB_W-1:0] RST_RGB         = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_GLYPH_WRITE = 2'd0,
        KIND_CLEAR       = 2'd1,
        KIND_BEGIN       = 2'd2,
        KIND_CHAR        = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ACK    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_FIRST_CODE  = 2'd0,
        CFG_GLYPH_COUNT = 2'd1,
        CFG_INST_LIMIT  = 2'd2,
        CFG_TEXT_COLOR  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]       first_code;
        logic [8:0]       glyph_count;
        logic [7:0]       instance_limit;
        logic [RGB_W-1:0] rgb;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        logic [15:0] pen_x;
        logic [15:0] pen_y;
    } t_item;

    // table entry, offsets in the low bytes
    typedef struct packed {
        logic [7:0] height;
        logic [7:0] advance;
        logic [7:0] dy;
        logic [7:0] dx;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   glyph_id;
        logic [15:0]       place_x;
        logic [15:0]       place_y;
        logic [RGB_W-1:0]  color_rgb;
        logic [15:0]       run_width;
        logic [7:0]        run_height;
    } t_result;

    // clamp a 17-bit signed sum into the signed 16-bit range
    function automatic logic [15:0] sat16(input logic [16:0] s);
        logic [15:0] r;
        if (s[16] != s[15]) begin
            r = s[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/grl_place.sv
`timescale 1ns / 1ps
// grl_place: run state (pen, baseline, instance count, run measure) and
// placement of one item from its table entry; depends on grl_pkg

module grl_place (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  grl_pkg::t_item   i_item,
    input  grl_pkg::t_entry  i_entry,
    input  grl_pkg::t_cfg    i_cfg,
    output grl_pkg::t_result o_result
);

    logic [15:0]                r_pen;
    logic [15:0]                r_base;
    logic [grl_pkg::CNT_W-1:0]  r_count;
    logic [15:0]                r_width;
    logic [7:0]                 r_height;

    logic [15:0]                n_pen;
    logic [15:0]                n_base;
    logic [grl_pkg::CNT_W-1:0]  n_count;
    logic [15:0]                n_width;
    logic [7:0]                 n_height;

    logic [7:0]  diff;
    logic        in_range;
    logic [15:0] limit;
    logic        full;
    logic [16:0] x_sum;
    logic [16:0] y_sum;
    logic [16:0] pen_sum;
    logic [16:0] width_sum;

    always_comb begin
        diff     = i_item.code - i_cfg.first_code;
        in_range = (i_item.code >= i_cfg.first_code)
                && ({1'b0, diff} < i_cfg.glyph_count)
                && ({1'b0, diff} < grl_pkg::TABLE_DEPTH_W);
        limit    = (16'(i_cfg.instance_limit) < grl_pkg::MAX_INST_W)
                 ? 16'(i_cfg.instance_limit) : grl_pkg::MAX_INST_W;
        full     = 16'(r_count) >= limit;

        x_sum     = {r_pen[15], r_pen} + {{9{i_entry.dx[7]}}, i_entry.dx};
        y_sum     = {r_base[15], r_base} - {{9{i_entry.dy[7]}}, i_entry.dy};
        pen_sum   = {r_pen[15], r_pen} + {9'd0, i_entry.advance};
        width_sum = {1'b0, r_width} + {9'd0, i_entry.advance};

        n_pen    = r_pen;
        n_base   = r_base;
        n_count  = r_count;
        n_width  = r_width;
        n_height = r_height;

        o_result           = '0;
        o_result.status    = grl_pkg::ST_ACK;

        case (i_item.kind)
            grl_pkg::KIND_GLYPH_WRITE: begin
            end
            grl_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            grl_pkg::KIND_BEGIN: begin
                n_pen    = i_item.pen_x;
                n_base   = i_item.pen_y;
                n_width  = '0;
                n_height = '0;
            end
            grl_pkg::KIND_CHAR: begin
                if (full) begin
                    o_result.status = grl_pkg::ST_FULL;
                end else if (!in_range) begin
                    o_result.status = grl_pkg::ST_RANGE;
                end else begin
                    o_result.status    = grl_pkg::ST_PLACED;
                    o_result.slot      = grl_pkg::SLOT_W'(r_count);
                    o_result.glyph_id  = grl_pkg::ID_W'(diff)
                                       * grl_pkg::ID_W'(grl_pkg::ID_SCALE);
                    o_result.place_x   = grl_pkg::sat16(x_sum);
                    o_result.place_y   = grl_pkg::sat16(y_sum);
                    o_result.color_rgb = i_cfg.rgb;
                    n_count  = r_count + 1'b1;
                    n_pen    = grl_pkg::sat16(pen_sum);
                    n_width  = width_sum[16] ? 16'hFFFF : width_sum[15:0];
                    n_height = (i_entry.height > r_height) ? i_entry.height : r_height;
                end
            end
            default: begin
            end
        endcase

        o_result.run_width  = n_width;
        o_result.run_height = n_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen    <= '0;
            r_base   <= '0;
            r_count  <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_step) begin
            r_pen    <= n_pen;
            r_base   <= n_base;
            r_count  <= n_count;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

endmodule

>>> rtl/glyph_run_layout.sv
`timescale 1ns / 1ps
// glyph_run_layout: top level with config registers, glyph table memory,
// input stage and result register; depends on grl_pkg and grl_place
//
// Usage: each input beat on s_axis carries one item, its kind in tuser
// (glyph write, clear instances, begin run, character). Every item gives
// exactly one result beat on m_axis, in order, status in tuser.
// Glyph writes load the table at the beat they are accepted; a character
// reads the table entry for code - first_code in the same cycle and is
// placed against the current pen, baseline and run measure.
// Config registers are written on the cfg channel (always ready); the user
// must write them only while no item is in flight; the block does not enforce it.
// An item is held in the input stage, its result in the output register.
// Throughput: one item per cycle while m_axis is ready, set by the single
// table read port and the single-register pen and run-measure update.
// Reset clears pen, baseline, instance count, run measure and sets the
// config registers to their defaults; table entries are undefined until
// written. When m_axis stalls, one result waits in the output register and
// one more item in the input stage, then s_axis_tready drops.

module glyph_run_layout (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s_axis_tdata: code[7:0], pen_x[23:8], pen_y[39:24], glyph_dx[47:40],
    // glyph_dy[55:48], glyph_advance[63:56], glyph_height[71:64]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,  // kind[1:0]
    // m_axis_tdata: slot[6:0], glyph_id[17:7], place_x[33:18],
    // place_y[49:34], color_rgb[73:50], run_width[89:74],
    // run_height[97:90], zero[103:98]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // status[1:0]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    grl_pkg::t_cfg    r_cfg;
    grl_pkg::t_entry  r_table [grl_pkg::TABLE_DEPTH];
    grl_pkg::t_entry  r_rd_entry;
    grl_pkg::t_item   r_s1_item;
    logic             r_s1_valid;
    grl_pkg::t_result r_out;
    logic             r_out_valid;

    grl_pkg::t_item          in_item;
    grl_pkg::t_entry         in_entry;
    grl_pkg::t_result        result;
    logic [7:0]              rd_diff;
    logic [grl_pkg::ADDR_W-1:0] rd_addr;
    logic                    s_accept;
    logic                    out_free;
    logic                    step;
    logic                    wr_en;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item.kind   = grl_pkg::t_kind'(s_axis_tuser);
        in_item.code   = s_axis_tdata[7:0];
        in_item.pen_x  = s_axis_tdata[23:8];
        in_item.pen_y  = s_axis_tdata[39:24];
        in_entry.dx      = s_axis_tdata[47:40];
        in_entry.dy      = s_axis_tdata[55:48];
        in_entry.advance = s_axis_tdata[63:56];
        in_entry.height  = s_axis_tdata[71:64];

        out_free      = !r_out_valid || m_axis_tready;
        step          = r_s1_valid && out_free;
        s_axis_tready = !r_s1_valid || out_free;
        s_accept      = s_axis_tvalid && s_axis_tready;

        rd_diff = in_item.code - r_cfg.first_code;
        rd_addr = rd_diff[grl_pkg::ADDR_W-1:0];
        wr_en   = s_accept && (in_item.kind == grl_pkg::KIND_GLYPH_WRITE)
               && ({1'b0, in_item.code} < grl_pkg::TABLE_DEPTH_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_code     <= grl_pkg::RST_FIRST_CODE;
            r_cfg.glyph_count    <= grl_pkg::RST_GLYPH_COUNT;
            r_cfg.instance_limit <= grl_pkg::RST_INST_LIMIT;
            r_cfg.rgb            <= grl_pkg::RST_RGB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (grl_pkg::t_cfg_idx'(i_cfg_index))
                grl_pkg::CFG_FIRST_CODE:  r_cfg.first_code     <= i_cfg_data[7:0];
                grl_pkg::CFG_GLYPH_COUNT: r_cfg.glyph_count    <= i_cfg_data[8:0];
                grl_pkg::CFG_INST_LIMIT:  r_cfg.instance_limit <= i_cfg_data[7:0];
                grl_pkg::CFG_TEXT_COLOR:  r_cfg.rgb <= i_cfg_data[grl_pkg::RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // glyph table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[in_item.code[grl_pkg::ADDR_W-1:0]] <= in_entry;
        end
        if (s_accept) begin
            r_rd_entry <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_item <= in_item;
        end
        if (step) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (step) begin
                r_s1_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    grl_place u_place (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_entry  (r_rd_entry),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {6'd0, r_out.run_height, r_out.run_width, r_out.color_rgb,
                            r_out.place_y, r_out.place_x, r_out.glyph_id, r_out.slot};

endmodule

>>> rtl/grl_checker.sv
`timescale 1ns / 1ps
// grl_checker: port-level assertions for glyph_run_layout, bound to the top
// depends on grl_pkg

module grl_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // only placed beats carry placement fields
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != grl_pkg::ST_PLACED) |-> m_axis_tdata[73:0] == '0)
        else $error("placement fields set on unplaced beat");

    // glyph id is a multiple of the vertex stride, so never odd
    a_id_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == grl_pkg::ST_PLACED) |-> !m_axis_tdata[7])
        else $error("odd glyph id on placed beat");

    // an empty input stage and result register always take a beat
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && $past(i_rst_n) && !$past(s_axis_tvalid && s_axis_tready)
        |-> s_axis_tready)
        else $error("input stalled with nothing in flight");

endmodule

bind glyph_run_layout grl_checker u_grl_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random stimulus for glyph_run_layout, with a layout
// predictor class and in-order checking of every result beat; needs grl_pkg

module testbench;
    import grl_pkg::*;

    // same bit order as {s_axis_tdata, s_axis_tuser}
    typedef struct packed {
        logic [7:0]         height;
        logic [7:0]         advance;
        logic signed [7:0]  dy;
        logic signed [7:0]  dx;
        logic signed [15:0] pen_y;
        logic signed [15:0] pen_x;
        logic [7:0]         code;
        t_kind              kind;
    } layout_item_t;

    class layout_predictor;
        t_entry      glyph_mem [TABLE_DEPTH];
        int          pen;
        int          base;
        int          placed;
        int          run_w;
        int          run_h;
        int          first_code = RST_FIRST_CODE;
        int          glyph_count = RST_GLYPH_COUNT;
        int          inst_limit = RST_INST_LIMIT;
        logic [31:0] color = 32'hFFFF_FFFF;
        t_result     pending_places [$];
        int          errors;

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_FIRST_CODE:  first_code = val[7:0];
                CFG_GLYPH_COUNT: glyph_count = val[8:0];
                CFG_INST_LIMIT:  inst_limit = val[7:0];
                CFG_TEXT_COLOR:  color = val;
                default: ;
            endcase
        endfunction

        function int clamp16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void accept_item(layout_item_t it);
            t_result r;
            t_entry  e;
            int      n;
            int      lim;
            r = '0;
            r.status = ST_ACK;
            n = int'(it.code) - first_code;
            case (it.kind)
                KIND_GLYPH_WRITE: glyph_mem[it.code] = {it.height, it.advance, it.dy, it.dx};
                KIND_CLEAR:       placed = 0;
                KIND_BEGIN: begin
                    pen = $signed(it.pen_x);
                    base = $signed(it.pen_y);
                    run_w = 0;
                    run_h = 0;
                end
                default: begin
                    lim = (inst_limit < MAX_INSTANCES) ? inst_limit : MAX_INSTANCES;
                    if (placed >= lim) begin
                        r.status = ST_FULL;
                    end else if (n < 0 || n >= glyph_count || n >= TABLE_DEPTH) begin
                        r.status = ST_RANGE;
                    end else begin
                        e = glyph_mem[n];
                        r.status    = ST_PLACED;
                        r.slot      = SLOT_W'(placed);
                        r.glyph_id  = ID_W'(n * ID_SCALE);
                        r.place_x   = 16'(clamp16(pen + $signed(e.dx)));
                        r.place_y   = 16'(clamp16(base - $signed(e.dy)));
                        r.color_rgb = color[RGB_W-1:0];
                        placed++;
                        pen = clamp16(pen + int'(e.advance));
                        run_w = run_w + int'(e.advance);
                        if (run_w > 65535) run_w = 65535;
                        if (int'(e.height) > run_h) run_h = e.height;
                    end
                end
            endcase
            r.run_width  = 16'(run_w);
            r.run_height = 8'(run_h);
            pending_places.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_place(t_result got);
            t_result want;
            if (pending_places.size() == 0) begin
                $error("result beat with nothing expected, status %0d", got.status);
                errors++;
                return;
            end
            want = pending_places.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot", want.slot, got.slot);
            compare_field("glyph_id", want.glyph_id, got.glyph_id);
            compare_field("place_x", want.place_x, got.place_x);
            compare_field("place_y", want.place_y, got.place_y);
            compare_field("color_rgb", want.color_rgb, got.color_rgb);
            compare_field("run_width", want.run_width, got.run_width);
            compare_field("run_height", want.run_height, got.run_height);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    layout_predictor layout;
    bit              written [TABLE_DEPTH];
    int              cur_fc;
    int              cur_gc;
    bit              long_run;
    bit              quiet;

    glyph_run_layout dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            layout.accept_item(layout_item_t'({s_axis_tdata, s_axis_tuser}));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status     = t_status'(m_axis_tuser);
            seen.slot       = m_axis_tdata[6:0];
            seen.glyph_id   = m_axis_tdata[17:7];
            seen.place_x    = m_axis_tdata[33:18];
            seen.place_y    = m_axis_tdata[49:34];
            seen.color_rgb  = m_axis_tdata[73:50];
            seen.run_width  = m_axis_tdata[89:74];
            seen.run_height = m_axis_tdata[97:90];
            layout.check_place(seen);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            layout.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
        end
    end

    // result side; two long hold-offs let the block fill up
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 3);
            if (taken == 300 || taken == 700) gap = 60;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic layout_item_t make_item(t_kind k, logic [7:0] code);
        layout_item_t it;
        it = 74'({$urandom, $urandom, $urandom});
        it.kind = k;
        it.code = code;
        return it;
    endfunction

    function automatic layout_item_t glyph_wr(logic [7:0] idx, logic [7:0] dx, logic [7:0] dy,
                                              logic [7:0] adv, logic [7:0] h);
        layout_item_t it;
        it = make_item(KIND_GLYPH_WRITE, idx);
        it.dx = dx;
        it.dy = dy;
        it.advance = adv;
        it.height = h;
        written[idx] = 1'b1;
        return it;
    endfunction

    function automatic layout_item_t begin_at(logic [15:0] x, logic [15:0] y);
        layout_item_t it;
        it = make_item(KIND_BEGIN, 8'($urandom));
        it.pen_x = x;
        it.pen_y = y;
        return it;
    endfunction

    // pen start, often close to either end of the range
    function automatic logic [15:0] pick_pen();
        case ($urandom_range(0, 2))
            0: return 16'(32767 - $urandom_range(0, 700));
            1: return 16'(-32768 + $urandom_range(0, 700));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic next_item(output layout_item_t it);
        int span;
        int roll;
        int n;
        it = 74'({$urandom, $urandom, $urandom});
        span = (cur_gc < TABLE_DEPTH - cur_fc) ? cur_gc : TABLE_DEPTH - cur_fc;
        roll = $urandom_range(0, 99);
        if (roll < 62) begin
            it.kind = KIND_CHAR;
            if (span > 0 && (long_run || $urandom_range(0, 3) != 0)) begin
                it.code = 8'(cur_fc + $urandom_range(0, span - 1));
            end
            n = int'(it.code) - cur_fc;
            // never place from an entry that holds nothing yet: load it instead
            if (n >= 0 && n < span && !written[n]) begin
                it.kind = KIND_GLYPH_WRITE;
                it.code = 8'(n);
            end
        end else if (roll < (long_run ? 90 : 82)) begin
            it.kind = KIND_GLYPH_WRITE;
            if (span > 0 && $urandom_range(0, 2) != 0) begin
                it.code = 8'($urandom_range(0, span - 1));
            end
        end else if (roll < 90) begin
            it.kind = KIND_BEGIN;
            it.pen_x = pick_pen();
            it.pen_y = pick_pen();
        end else begin
            it.kind = KIND_CLEAR;
        end
        if (it.kind == KIND_GLYPH_WRITE) begin
            written[it.code] = 1'b1;
            if (long_run) it.advance = 8'hFF;
        end
    endtask

    task automatic send_item(input layout_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        {s_axis_tdata, s_axis_tuser} <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (layout.pending_places.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] fc, input logic [8:0] gc,
                              input logic [7:0] lim, input logic [31:0] color);
        i_cfg_valid <= 1'b1;
        put_reg(CFG_FIRST_CODE, 32'(fc));
        put_reg(CFG_GLYPH_COUNT, 32'(gc));
        put_reg(CFG_INST_LIMIT, 32'(lim));
        put_reg(CFG_TEXT_COLOR, color);
        i_cfg_valid <= 1'b0;
        cur_fc = fc;
        cur_gc = gc;
    endtask

    task automatic random_phase(input logic [7:0] fc, input logic [8:0] gc,
                                input logic [7:0] lim, input logic [31:0] color,
                                input int count);
        layout_item_t it;
        settle();
        write_regs(fc, gc, lim, color);
        repeat (count) begin
            next_item(it);
            send_item(it);
        end
    endtask

    initial begin : stimulus
        layout_item_t plan [$];
        layout = new();
        quiet = 1'b0;
        long_run = 1'b0;
        cur_fc = RST_FIRST_CODE;
        cur_gc = RST_GLYPH_COUNT;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty range, every character is skipped
        plan.push_back(make_item(KIND_CHAR, 8'd32));
        plan.push_back(make_item(KIND_CHAR, 8'd255));
        plan.push_back(make_item(KIND_CLEAR, 8'd0));
        plan.push_back(begin_at(16'd100, 16'hFF9C));
        plan.push_back(make_item(KIND_CHAR, 8'd200));
        foreach (plan[i]) send_item(plan[i]);
        settle();

        // offset, pen and buffer limit corners with a four-slot buffer
        write_regs(8'd32, 9'd96, 8'd4, 32'h1234_5678);
        plan.delete();
        plan.push_back(glyph_wr(8'd0, 8'h7F, 8'h80, 8'hFF, 8'hFF));
        plan.push_back(glyph_wr(8'd1, 8'h80, 8'h7F, 8'h00, 8'h00));
        plan.push_back(glyph_wr(8'd95, 8'h05, 8'hFD, 8'd17, 8'd9));
        plan.push_back(glyph_wr(8'd255, 8'h00, 8'h00, 8'h55, 8'hAA));
        plan.push_back(begin_at(16'h7FFF, 16'h8000));
        plan.push_back(make_item(KIND_CHAR, 8'd32));
        plan.push_back(make_item(KIND_CHAR, 8'd33));
        plan.push_back(make_item(KIND_CHAR, 8'd31));
        plan.push_back(make_item(KIND_CHAR, 8'd128));
        plan.push_back(make_item(KIND_CHAR, 8'd127));
        plan.push_back(begin_at(16'h8000, 16'h7FFF));
        plan.push_back(make_item(KIND_CHAR, 8'd33));
        plan.push_back(make_item(KIND_CHAR, 8'd32));
        plan.push_back(make_item(KIND_CHAR, 8'd255));
        plan.push_back(make_item(KIND_CLEAR, 8'd0));
        plan.push_back(make_item(KIND_CHAR, 8'd32));
        plan.push_back(glyph_wr(8'd2, 8'hC3, 8'h3C, 8'h0F, 8'hF0));
        plan.push_back(begin_at(16'h0000, 16'h0000));
        plan.push_back(make_item(KIND_CHAR, 8'd34));
        plan.push_back(make_item(KIND_CHAR, 8'd0));
        plan.push_back(make_item(KIND_CLEAR, 8'd0));
        foreach (plan[i]) send_item(plan[i]);

        random_phase(8'd0, 9'd256, 8'd128, 32'hFFFF_FFFF, 300);
        random_phase(8'd255, 9'd1, 8'd1, 32'h0000_0000, 150);
        // no begins and full advances so the run width saturates
        long_run = 1'b1;
        random_phase(8'd200, 9'd56, 8'd255, $urandom, 500);
        long_run = 1'b0;
        random_phase(8'd16, 9'd0, 8'd0, 32'hA5A5_A5A5, 50);
        quiet = 1'b1;
        random_phase(8'd64, 9'd128, 8'd100, $urandom, 250);
        settle();

        if (layout.errors == 0 && layout.pending_places.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
